/* rtl/core/assert_macros.svh */
// Concurrent assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

/* rtl/core/lru_pr_pkg.sv */
`timescale 1ns / 1ps

package lru_pr_pkg;

   localparam int MAX_FRAMES_DEF = 8;
   localparam int PAGE_COUNT_DEF = 16;

   localparam int PAGE_W = 4;
   localparam int FILL_W = 4;

   localparam logic [FILL_W-1:0] FRAMES_RESET = 4'd4;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef enum logic [1:0] {
      MODE_HIT,
      MODE_EVICT,
      MODE_INSERT
   } mode_type;

endpackage

/* rtl/core/lru_pr_ram.sv */
`timescale 1ns / 1ps

module lru_pr_ram
   import lru_pr_pkg::*;
#(
   parameter int DEPTH = MAX_FRAMES_DEF,
   parameter int WIDTH = PAGE_W,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lru_page_replacement_top.sv */
`timescale 1ns / 1ps
// LRU page replacement.
// Request: pulse start with req_page_number while busy is low; the request is
// taken at that edge. Busy stays high while the recency stack is walked.
// Response: rsp_strobe is high for exactly one cycle with rsp_hit, rsp_evicted,
// rsp_evicted_page and rsp_frames_filled. The receiver cannot stall; every
// response must be taken in its cycle.
// Walk: the recency stack sits in a single-port-write, registered-read RAM,
// one entry read and one written per cycle while walking. A hit walks to the
// page's stack position, a miss with a free frame to the fill point and an
// eviction to the last filled entry. The registered response follows in the
// cycle after the walk ends, when the next request can already be taken.
// A page at or above PAGE_COUNT is answered in the next cycle without change.
// csr_write_enable/csr_write_data set the usable frame count; write only when
// idle. Reset (synchronous, active high) clears the residency map and the fill
// count and sets the frame count to 4; no clearing pass is needed.

`include "assert_macros.svh"

module lru_page_replacement_top
   import lru_pr_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [PAGE_W-1:0] req_page_number,
   output logic              rsp_strobe,
   output logic              rsp_hit,
   output logic              rsp_evicted,
   output logic [PAGE_W-1:0] rsp_evicted_page,
   output logic [FILL_W-1:0] rsp_frames_filled,
   input  logic              csr_write_enable,
   input  logic [FILL_W-1:0] csr_write_data
);

   localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W     = (FILL_W > IDX_W + 1) ? FILL_W : IDX_W + 1;
   localparam int MAP_DEPTH = (PAGE_COUNT < (2 ** PAGE_W)) ? PAGE_COUNT : (2 ** PAGE_W);
   localparam int MAP_IDX_W = $clog2(MAP_DEPTH);
   localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_FRAMES);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [PAGE_W-1:0]      page_ff, page_in;
   logic [PAGE_W-1:0]      carry_ff, carry_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       end_ff, end_in;
   logic [FILL_W-1:0]      filled_ff, filled_in;
   logic [MAP_DEPTH-1:0]   resident_ff, resident_in;
   logic [FILL_W-1:0]      frames_ff;
   logic                   strobe_ff, strobe_in;
   logic                   hit_ff, hit_in;
   logic                   evicted_ff, evicted_in;
   logic [PAGE_W-1:0]      victim_ff, victim_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_raddr;
   logic [PAGE_W-1:0]      ram_rdata;

   logic                   page_valid;
   logic [MAP_IDX_W-1:0]   req_map_idx;
   logic [CNT_W-1:0]       fill_ext;
   logic [CNT_W-1:0]       limit;
   logic [CNT_W-1:0]       last;
   logic                   walk_done;

   lru_pr_ram #(
      .DEPTH (MAX_FRAMES),
      .WIDTH (PAGE_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (carry_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign page_valid  = 32'(req_page_number) < PAGE_COUNT;
   assign req_map_idx = req_page_number[MAP_IDX_W-1:0];
   assign fill_ext    = CNT_W'(filled_ff);

   always_comb begin
      limit = CNT_W'(frames_ff);
      if (limit == '0) begin
         limit = ONE_C;
      end else if (limit > MAX_C) begin
         limit = MAX_C;
      end
      last = fill_ext - ONE_C;
      if (last > MAX_C - ONE_C) begin
         last = MAX_C - ONE_C;
      end
   end

   assign walk_done = ((mode_ff == MODE_HIT) && (ram_rdata == page_ff)) || (idx_ff == end_ff);

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      page_in     = page_ff;
      carry_in    = carry_ff;
      idx_in      = idx_ff;
      end_in      = end_ff;
      filled_in   = filled_ff;
      resident_in = resident_ff;
      strobe_in   = 1'b0;
      hit_in      = hit_ff;
      evicted_in  = evicted_ff;
      victim_in   = victim_ff;
      ram_we      = 1'b0;
      ram_raddr   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!page_valid) begin
                  strobe_in  = 1'b1;
                  hit_in     = 1'b0;
                  evicted_in = 1'b0;
                  victim_in  = '0;
               end else begin
                  page_in  = req_page_number;
                  carry_in = req_page_number;
                  idx_in   = '0;
                  state_in = ST_WALK;
                  if (resident_ff[req_map_idx]) begin
                     mode_in = MODE_HIT;
                     end_in  = last[IDX_W-1:0];
                  end else if ((fill_ext >= limit) && (fill_ext != '0)) begin
                     mode_in = MODE_EVICT;
                     end_in  = last[IDX_W-1:0];
                  end else begin
                     mode_in = MODE_INSERT;
                     end_in  = fill_ext[IDX_W-1:0];
                  end
               end
            end
         end
         ST_WALK: begin
            ram_we    = 1'b1;
            ram_raddr = idx_ff + 1'b1;
            if (walk_done) begin
               state_in   = ST_IDLE;
               strobe_in  = 1'b1;
               hit_in     = (mode_ff == MODE_HIT);
               evicted_in = (mode_ff == MODE_EVICT);
               victim_in  = (mode_ff == MODE_EVICT) ? ram_rdata : '0;
               if (mode_ff == MODE_EVICT) begin
                  resident_in[ram_rdata[MAP_IDX_W-1:0]] = 1'b0;
               end
               if (mode_ff == MODE_INSERT) begin
                  filled_in = filled_ff + 1'b1;
               end
               resident_in[page_ff[MAP_IDX_W-1:0]] = 1'b1;
            end else begin
               carry_in = ram_rdata;
               idx_in   = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         filled_ff   <= '0;
         resident_ff <= '0;
         frames_ff   <= FRAMES_RESET;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         filled_ff   <= filled_in;
         resident_ff <= resident_in;
         strobe_ff   <= strobe_in;
         if (csr_write_enable) begin
            frames_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      page_ff    <= page_in;
      carry_ff   <= carry_in;
      idx_ff     <= idx_in;
      end_ff     <= end_in;
      hit_ff     <= hit_in;
      evicted_ff <= evicted_in;
      victim_ff  <= victim_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted       = evicted_ff;
   assign rsp_evicted_page  = victim_ff;
   assign rsp_frames_filled = filled_ff;

   `ASSERT_NEVER(a_fill_bound, clock, reset, CNT_W'(filled_ff) > MAX_C, "fill count above frame count")
   `ASSERT_NEVER(a_hit_evict, clock, reset, rsp_strobe && rsp_hit && rsp_evicted, "hit reported with eviction")
   `ASSERT_NEVER(a_hit_walk, clock, reset, (state_ff == ST_WALK) && (mode_ff == MODE_HIT) && (CNT_W'(idx_ff) >= fill_ext), "hit walk ran past fill")
   `ASSERT_HOLDS(a_strobe_src, clock, reset, rsp_strobe |-> ($past(state_ff == ST_WALK) || $past(start && !busy)), "response without request")

endmodule
